/* design/i2p_pkg.sv */
// shared types, character codes and helper functions of the infix-to-postfix converter
`timescale 1ns / 1ps
`default_nettype none
package i2p_pkg;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_MUL  = 2'd2;

    typedef enum logic [2:0] {
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OPER,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        logic load_item;
        logic emit_char;
        logic pop_emit;
        logic pop_drop;
        logic push;
        logic release_last;
        logic emit_marker;
    } i2p_cmd_t;

    typedef struct packed {
        char_class_t item_class;
        logic        item_end;
        logic        empty;
        logic        top_match;
        logic        top_prec_ge;
        logic        hold_valid;
        logic        out_free;
        logic        overflow;
    } i2p_status_t;

    function automatic logic [1:0] prec(logic [7:0] c);
        logic [1:0] p;
        p = PREC_NONE;
        if (c inside {CH_PLUS, CH_MINUS})
            p = PREC_ADD;
        else if (c inside {CH_STAR, CH_SLASH, CH_PCT})
            p = PREC_MUL;
        return p;
    endfunction

    function automatic char_class_t classify(logic [7:0] c);
        char_class_t k;
        if (c inside {[CH_DIG_LO:CH_DIG_HI], [CH_UC_LO:CH_UC_HI], [CH_LC_LO:CH_LC_HI]})
            k = CLS_ALNUM;
        else if (c inside {CH_LPAREN, CH_LBRACK, CH_LBRACE})
            k = CLS_OPEN;
        else if (c inside {CH_RPAREN, CH_RBRACK, CH_RBRACE})
            k = CLS_CLOSE;
        else if (prec(c) != PREC_NONE)
            k = CLS_OPER;
        else
            k = CLS_OTHER;
        return k;
    endfunction

    function automatic logic [7:0] opener_of(logic [7:0] c);
        logic [7:0] o;
        case (c)
            CH_RPAREN: o = CH_LPAREN;
            CH_RBRACK: o = CH_LBRACK;
            default:   o = CH_LBRACE;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

/* design/i2p_in_if.sv */
// input channel: one infix character per transaction
`timescale 1ns / 1ps
`default_nettype none
interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_expr;

    modport source (output valid, output char_in, output end_of_expr, input ready);
    modport sink (input valid, input char_in, input end_of_expr, output ready);
endinterface
`default_nettype wire

/* design/i2p_out_if.sv */
// output channel: one postfix result per transaction
`timescale 1ns / 1ps
`default_nettype none
interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       char_valid;
    logic       last_of_item;
    logic       expr_done;
    logic       overflow;

    modport source (output valid, output char_out, output char_valid, output last_of_item,
                    output expr_done, output overflow, input ready);
    modport sink (input valid, input char_out, input char_valid, input last_of_item,
                  input expr_done, input overflow, output ready);
endinterface
`default_nettype wire

/* design/i2p_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* design/i2p_datapath.sv */
// operator stack, item registers, one-entry hold stage and output register
`timescale 1ns / 1ps
`default_nettype none
module i2p_datapath import i2p_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    i2p_in_if.sink        in_item,
    i2p_out_if.source     out_item,
    input  wire i2p_cmd_t cmd,
    output i2p_status_t   sts
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          overflow_reg, overflow_next;
    logic [7:0]    char_reg;
    logic          end_reg;
    logic          byp_valid_reg;
    logic [7:0]    byp_data_reg;
    logic          hold_valid_reg, hold_valid_next;
    logic [7:0]    hold_char_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg;
    logic          out_cv_reg;
    logic          out_last_reg;
    logic          out_done_reg;
    logic          out_ovf_reg;

    logic          full;
    logic          push_ok;
    logic [CW-1:0] top_idx;
    logic [7:0]    rdata;
    logic [7:0]    top;
    logic          load_hold;
    logic          shift_out;
    logic          out_free;

    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign push_ok = cmd.push && !full;

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (push_ok)
            count_next = count_reg + CW'(1);
        else if (cmd.pop_emit || cmd.pop_drop)
            count_next = count_reg - CW'(1);
        if (cmd.push && full)
            overflow_next = 1'b1;
    end

    // read address follows the next top so the top entry is ready every cycle
    assign top_idx = count_next - CW'(1);

    i2p_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push_ok),
        .waddr (count_reg[AW-1:0]),
        .wdata (char_reg),
        .raddr (top_idx[AW-1:0]),
        .rdata (rdata)
    );

    // a push is not yet visible at the ram read port in the cycle after it, so the bypass register supplies the top
    assign top = byp_valid_reg ? byp_data_reg : rdata;

    assign out_free  = !out_valid_reg || out_item.ready;
    assign load_hold = cmd.emit_char || cmd.pop_emit;
    assign shift_out = load_hold && hold_valid_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (load_hold)
            hold_valid_next = 1'b1;
        else if (cmd.release_last)
            hold_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_item.ready)
            out_valid_next = 1'b0;
        if (shift_out || cmd.release_last || cmd.emit_marker)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            byp_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            byp_valid_reg  <= push_ok;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            char_reg <= in_item.char_in;
            end_reg  <= in_item.end_of_expr;
        end
        if (push_ok)
            byp_data_reg <= char_reg;
        if (load_hold)
            hold_char_reg <= cmd.emit_char ? char_reg : top;
        if (shift_out)
        begin
            out_char_reg <= hold_char_reg;
            out_cv_reg   <= 1'b1;
            out_last_reg <= 1'b0;
            out_done_reg <= 1'b0;
            out_ovf_reg  <= overflow_reg;
        end
        else if (cmd.release_last)
        begin
            out_char_reg <= hold_char_reg;
            out_cv_reg   <= 1'b1;
            out_last_reg <= 1'b1;
            out_done_reg <= end_reg;
            out_ovf_reg  <= overflow_reg;
        end
        else if (cmd.emit_marker)
        begin
            out_char_reg <= CH_NUL;
            out_cv_reg   <= 1'b0;
            out_last_reg <= 1'b1;
            out_done_reg <= 1'b1;
            out_ovf_reg  <= overflow_reg;
        end
    end

    assign out_item.valid        = out_valid_reg;
    assign out_item.char_out     = out_char_reg;
    assign out_item.char_valid   = out_cv_reg;
    assign out_item.last_of_item = out_last_reg;
    assign out_item.expr_done    = out_done_reg;
    assign out_item.overflow     = out_ovf_reg;

    always_comb
    begin
        sts.item_class  = classify(char_reg);
        sts.item_end    = end_reg;
        sts.empty       = (count_reg == '0);
        sts.top_match   = (top == opener_of(char_reg));
        sts.top_prec_ge = (prec(top) >= prec(char_reg));
        sts.hold_valid  = hold_valid_reg;
        sts.out_free    = out_free;
        sts.overflow    = overflow_reg;
    end

endmodule
`default_nettype wire

/* design/i2p_ctrl.sv */
// controller: sequences pushes, pops and result releases for one character
`timescale 1ns / 1ps
`default_nettype none
module i2p_ctrl import i2p_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire i2p_status_t sts,
    output i2p_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_LAST = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   char_done_reg, char_done_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        char_done_next = char_done_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item  = 1'b1;
                    char_done_next = 1'b0;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                // every step waits for room in the output register
                if (sts.out_free)
                begin
                    if (!char_done_reg)
                    begin
                        char_done_next = 1'b1;
                        case (sts.item_class)
                            CLS_ALNUM: cmd.emit_char = 1'b1;
                            CLS_OPEN:  cmd.push = 1'b1;
                            CLS_CLOSE:
                            begin
                                if (!sts.empty && !sts.top_match)
                                begin
                                    cmd.pop_emit   = 1'b1;
                                    char_done_next = 1'b0;
                                end
                                else if (!sts.empty)
                                begin
                                    cmd.pop_drop = 1'b1;
                                end
                            end
                            CLS_OPER:
                            begin
                                if (!sts.empty && sts.top_prec_ge)
                                begin
                                    cmd.pop_emit   = 1'b1;
                                    char_done_next = 1'b0;
                                end
                                else
                                begin
                                    cmd.push = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        if (char_done_next && !sts.item_end)
                            state_next = S_LAST;
                    end
                    else if (sts.item_end && !sts.empty)
                    begin
                        cmd.pop_emit = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                if (sts.out_free)
                begin
                    if (sts.hold_valid)
                        cmd.release_last = 1'b1;
                    else if (sts.item_end)
                        cmd.emit_marker = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            char_done_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            char_done_reg <= char_done_next;
        end
    end

endmodule
`default_nettype wire

/* design/infix_to_postfix_converter.sv */
// top level of the shunting-yard infix-to-postfix converter
`timescale 1ns / 1ps
`default_nettype none
// Takes one ASCII character per input transaction and returns the postfix
// characters it causes, the last one flagged with last_of_item (and expr_done
// when end_of_expr was set; an item that ends an expression with nothing to
// emit returns one empty marker). Operators and brackets wait in a stack of
// STACK_DEPTH entries held in a ram. One character is taken at a time: the
// block is not ready again until it has finished every step for it, and every
// entry popped by a closing bracket, an operator or the end-of-expression flush
// takes a step of its own; a matched opener is discarded in the step that
// finishes the character. Results leave through an output register, so a sink
// that holds off ready stalls the converter.
module infix_to_postfix_converter import i2p_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    i2p_in_if.sink    in_item,
    i2p_out_if.source out_item
);

    i2p_cmd_t    cmd;
    i2p_status_t sts;

    i2p_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item),
        .cmd      (cmd),
        .sts      (sts)
    );

    // overflow is sticky until reset
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(sts.overflow))
        else $error("overflow flag cleared without reset");

    // pops only with something on the stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_emit || cmd.pop_drop) |-> !sts.empty)
        else $error("pop from empty stack");

    // a result is loaded only when the output register has room
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.release_last || cmd.emit_marker || (cmd.pop_emit && sts.hold_valid)
         || (cmd.emit_char && sts.hold_valid)) |-> sts.out_free)
        else $error("result loaded over a waiting transaction");

    // the end of an expression is always the last result of its item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.expr_done) |-> out_item.last_of_item)
        else $error("expr_done without last_of_item");

endmodule
`default_nettype wire

/* test/testbench.sv */
// self-checking testbench of the infix-to-postfix converter with an operator stack predictor
`timescale 1ns / 1ps
module testbench;
    import i2p_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int PHASE1_AT   = 50;
    localparam int PHASE2_AT   = 100;
    localparam int HOLD_AT     = 35;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoe;
        logic       wait_idle;
    } char_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       last;
        logic       done;
        logic       ovf;
    } postfix_res_t;

    logic clk;
    logic rst_n;

    i2p_in_if  in_ch ();
    i2p_out_if out_ch ();

    infix_to_postfix_converter #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    char_item_t   pending_q [$];
    postfix_res_t postfix_expect_q [$];

    // predictor copy of the operator stack
    logic [7:0] op_stack [STACK_DEPTH];
    int         op_count;
    logic       ovf_sticky;

    int   n_accepted;
    logic results_pending;
    int   fail_count = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_left;
    logic hold_done;

    assign send_idle_pct = (n_accepted < PHASE1_AT) ? 7 : (n_accepted < PHASE2_AT) ? 70 : 0;
    assign recv_idle_pct = (n_accepted < PHASE1_AT) ? 70 : (n_accepted < PHASE2_AT) ? 7 : 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    function automatic int op_rank(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS:         return 1;
            CH_STAR, CH_SLASH, CH_PCT: return 2;
            default:                   return 0;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(input logic [7:0] opener);
        case (opener)
            CH_LPAREN: return CH_RPAREN;
            CH_LBRACK: return CH_RBRACK;
            default:   return CH_RBRACE;
        endcase
    endfunction

    task automatic push_result(input logic [7:0] ch, input logic ch_valid);
        postfix_res_t r;
        r.ch       = ch;
        r.ch_valid = ch_valid;
        r.last     = 1'b0;
        r.done     = 1'b0;
        r.ovf      = 1'b0;
        postfix_expect_q.push_back(r);
    endtask

    task automatic pop_to_output(inout int n_out);
        op_count--;
        push_result(op_stack[op_count], 1'b1);
        n_out++;
    endtask

    task automatic predict_postfix(input logic [7:0] ch, input logic eoe);
        int           n_out;
        int           k;
        logic [7:0]   partner;
        postfix_res_t r;
        n_out = 0;
        if ((ch >= CH_DIG_LO && ch <= CH_DIG_HI) || (ch >= CH_UC_LO && ch <= CH_UC_HI) ||
            (ch >= CH_LC_LO && ch <= CH_LC_HI))
        begin
            push_result(ch, 1'b1);
            n_out++;
        end
        else if (ch == CH_LPAREN || ch == CH_LBRACK || ch == CH_LBRACE)
        begin
            if (op_count >= STACK_DEPTH)
                ovf_sticky = 1'b1;
            else
            begin
                op_stack[op_count] = ch;
                op_count++;
            end
        end
        else if (ch == CH_RPAREN || ch == CH_RBRACK || ch == CH_RBRACE)
        begin
            partner = (ch == CH_RPAREN) ? CH_LPAREN : (ch == CH_RBRACK) ? CH_LBRACK : CH_LBRACE;
            while (op_count > 0 && op_stack[op_count - 1] != partner)
                pop_to_output(n_out);
            if (op_count > 0)
                op_count--;
        end
        else if (op_rank(ch) > 0)
        begin
            // left-associative: equal precedence pops too
            while (op_count > 0 && op_rank(op_stack[op_count - 1]) >= op_rank(ch))
                pop_to_output(n_out);
            if (op_count >= STACK_DEPTH)
                ovf_sticky = 1'b1;
            else
            begin
                op_stack[op_count] = ch;
                op_count++;
            end
        end
        if (eoe)
        begin
            while (op_count > 0)
                pop_to_output(n_out);
            if (n_out == 0)
            begin
                push_result(CH_NUL, 1'b0);
                n_out++;
            end
        end
        for (k = postfix_expect_q.size() - n_out; k < postfix_expect_q.size(); k++)
        begin
            r     = postfix_expect_q[k];
            r.ovf = ovf_sticky;
            if (k == postfix_expect_q.size() - 1)
            begin
                r.last = 1'b1;
                r.done = eoe;
            end
            postfix_expect_q[k] = r;
        end
    endtask

    // input side: one character transaction at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        char_item_t nxt;
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.char_in     <= 8'h00;
            in_ch.end_of_expr <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_q[0].wait_idle && (in_ch.valid || results_pending)))
            begin
                nxt = pending_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.char_in     <= nxt.ch;
                in_ch.end_of_expr <= nxt.eoe;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // output side: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!hold_done && n_accepted >= HOLD_AT)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_results
        postfix_res_t want;
        if (!rst_n)
        begin
            n_accepted      <= 0;
            results_pending <= 1'b0;
            op_count         = 0;
            ovf_sticky       = 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_postfix(in_ch.char_in, in_ch.end_of_expr);
                n_accepted <= n_accepted + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (postfix_expect_q.size() == 0)
                    report_mismatch("unexpected result, char_out", out_ch.char_out, 0);
                else
                begin
                    want = postfix_expect_q.pop_front();
                    if (out_ch.char_out !== want.ch)
                        report_mismatch("char_out", out_ch.char_out, want.ch);
                    if (out_ch.char_valid !== want.ch_valid)
                        report_mismatch("char_valid", out_ch.char_valid, want.ch_valid);
                    if (out_ch.last_of_item !== want.last)
                        report_mismatch("last_of_item", out_ch.last_of_item, want.last);
                    if (out_ch.expr_done !== want.done)
                        report_mismatch("expr_done", out_ch.expr_done, want.done);
                    if (out_ch.overflow !== want.ovf)
                        report_mismatch("overflow", out_ch.overflow, want.ovf);
                end
            end
            results_pending <= (postfix_expect_q.size() != 0);
        end
    end

    task automatic add_char(input logic [7:0] ch, input logic eoe, input logic wait_idle);
        char_item_t it;
        it.ch        = ch;
        it.eoe       = eoe;
        it.wait_idle = wait_idle;
        pending_q.push_back(it);
    endtask

    task automatic mark_end();
        char_item_t it;
        it     = pending_q.pop_back();
        it.eoe = 1'b1;
        pending_q.push_back(it);
    endtask

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(61);
        if (r < 10)
            return 8'(CH_DIG_LO + r);
        else if (r < 36)
            return 8'(CH_UC_LO + (r - 10));
        return 8'(CH_LC_LO + (r - 36));
    endfunction

    function automatic logic [7:0] rand_opener();
        case ($urandom_range(2))
            0:       return CH_LPAREN;
            1:       return CH_LBRACK;
            default: return CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_PCT;
        endcase
    endfunction

    // well-formed expression with random content; now and then brackets are left open
    task automatic add_expression(input int n_operands, input int max_nest,
                                  input logic drain_first);
        logic [7:0] open_q [$];
        logic [7:0] opener;
        logic       hold_first;
        int         k;
        hold_first = drain_first;
        for (k = 0; k < n_operands; k++)
        begin
            while (open_q.size() < max_nest && $urandom_range(2) == 0)
            begin
                opener = rand_opener();
                open_q.push_back(opener);
                add_char(opener, 1'b0, hold_first);
                hold_first = 1'b0;
            end
            add_char(rand_alnum(), 1'b0, hold_first);
            hold_first = 1'b0;
            while (open_q.size() > 0 && $urandom_range(2) == 0)
                add_char(closer_of(open_q.pop_back()), 1'b0, 1'b0);
            if (k != n_operands - 1)
                add_char(rand_operator(), 1'b0, 1'b0);
        end
        if ($urandom_range(4) != 0)
            while (open_q.size() > 0)
                add_char(closer_of(open_q.pop_back()), 1'b0, 1'b0);
        mark_end();
    endtask

    task automatic add_broken();
        int k;
        int len;
        len = $urandom_range(3, 8);
        for (k = 0; k < len; k++)
            case ($urandom_range(3))
                0:       add_char(rand_opener(), 1'b0, 1'b0);
                1:       add_char(closer_of(rand_opener()), 1'b0, 1'b0);
                2:       add_char(rand_operator(), 1'b0, 1'b0);
                default: add_char(rand_alnum(), 1'b0, 1'b0);
            endcase
        mark_end();
    endtask

    initial
    begin : stimulus
        int n_random;
        int n_expr;
        int pick;
        int q_mark;
        int k;
        int nest;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.char_in     = 8'h00;
        in_ch.end_of_expr = 1'b0;
        out_ch.ready      = 1'b0;

        // directed: dropped bytes, empty end marker, every operator and bracket kind,
        // left associativity, a foreign opener popped by a closer, unmatched closers
        add_char(CH_NUL,    1'b0, 1'b0);
        add_char(8'hFF,     1'b1, 1'b0);
        add_char(CH_LBRACE, 1'b0, 1'b0);
        add_char(CH_UC_LO,  1'b0, 1'b0);
        add_char(CH_PLUS,   1'b0, 1'b0);
        add_char(CH_LPAREN, 1'b0, 1'b0);
        add_char(CH_DIG_HI, 1'b0, 1'b0);
        add_char(CH_STAR,   1'b0, 1'b0);
        add_char(CH_LC_LO,  1'b0, 1'b0);
        add_char(CH_SLASH,  1'b0, 1'b0);
        add_char(CH_UC_HI,  1'b0, 1'b0);
        add_char(CH_PCT,    1'b0, 1'b0);
        add_char(CH_LC_HI,  1'b0, 1'b0);
        add_char(CH_RPAREN, 1'b0, 1'b0);
        add_char(CH_MINUS,  1'b0, 1'b0);
        add_char(CH_LBRACK, 1'b0, 1'b0);
        add_char(CH_DIG_LO, 1'b0, 1'b0);
        add_char(CH_RBRACE, 1'b0, 1'b0);
        add_char(CH_RBRACK, 1'b1, 1'b0);
        add_char(CH_LPAREN, 1'b0, 1'b0);
        add_char(CH_PLUS,   1'b0, 1'b0);
        add_char(CH_RBRACK, 1'b0, 1'b0);
        add_char(CH_LBRACE, 1'b0, 1'b0);
        add_char(CH_STAR,   1'b0, 1'b0);
        add_char(8'(CH_DIG_LO + 1), 1'b1, 1'b0);

        n_random = 0;
        n_expr   = 0;
        while (n_random < 85)
        begin
            pick   = $urandom_range(99);
            q_mark = pending_q.size();
            if (pick < 12)
                add_char(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0);
            else if (pick < 22)
                add_broken();
            else
            begin
                nest = ($urandom_range(9) == 0) ? 12 : $urandom_range(4);
                add_expression($urandom_range(1, 5), nest, n_expr % 8 == 0);
                n_expr++;
            end
            n_random += pending_q.size() - q_mark;
        end

        // fill the stack past its depth, then flush it in one item
        for (k = 0; k < STACK_DEPTH + 2; k++)
            add_char(rand_opener(), 1'b0, k == 0);
        add_char(rand_operator(), 1'b0, 1'b0);
        add_char(rand_operator(), 1'b0, 1'b0);
        add_char(rand_alnum(), 1'b1, 1'b0);
        add_expression(3, 2, 1'b0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || in_ch.valid)
            @(negedge clk);
        while (postfix_expect_q.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
